// File: hdl/assert_macros.svh
// Assertion macros shared by the search unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KNTS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define KNTS_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: hdl/knts_pkg.sv
// Package for the k-nearest timestamp search unit: widths, codes, types.
// No dependencies; imported by the search unit and the difference unit.
package knts_pkg;

	localparam int TIME_W            = 63;
	localparam int ENTRY_INDEX_W     = 10;
	localparam int RANK_W            = 4;
	localparam int CMD_W             = 2;
	localparam int NCOUNT_W          = 5;
	localparam int NEIGHBOR_RESET    = 5;
	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int MAX_NEIGHBORS_DEF = 16;

	localparam int IN_TDATA_W   = ((TIME_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = ENTRY_INDEX_W + 2 * TIME_W + RANK_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SRCH_CMP,
		ST_LOAD_L,
		ST_CALC_L,
		ST_LOAD_R,
		ST_CALC_R,
		ST_PICK,
		ST_EMIT
	} state_t;

	// result of the shared compare/subtract unit
	typedef struct packed {
		logic              lt;
		logic [TIME_W-1:0] mag;
	} diff_t;

endpackage

// File: hdl/knts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the timestamp table.
module knts_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: hdl/knts_diff_unit.sv
// Shared 63-bit compare and absolute-difference unit.
// Depends on knts_pkg (TIME_W, diff_t).
module knts_diff_unit import knts_pkg::*; (
	input  logic [TIME_W-1:0] op_a,
	input  logic [TIME_W-1:0] op_b,
	output diff_t             res
);

	logic [TIME_W:0] d_ab;
	logic [TIME_W:0] d_ba;

	assign d_ab = {1'b0, op_a} - {1'b0, op_b};
	assign d_ba = {1'b0, op_b} - {1'b0, op_a};

	always_comb begin
		res.lt  = d_ab[TIME_W];
		res.mag = d_ab[TIME_W] ? d_ba[TIME_W-1:0] : d_ab[TIME_W-1:0];
	end

endmodule

// File: hdl/k_nearest_timestamp_search_unit.sv
// Append and clear are taken in IDLE. Query: accepted in IDLE, then a binary search with a
// SEARCH and SRCH_CMP state per step (floor(log2(entries))+1 steps at most), LOAD and CALC states
// to load both neighbors, then PICK and EMIT for each result, with EMIT held while m_tready is low.
// One transaction in flight; s_tready high between them.
// arst_n clears entry count, error flag and sequencer; neighbor_count resets to 5.
// Table RAM has no reset; entries are read only below the entry count.
module k_nearest_timestamp_search_unit import knts_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [NCOUNT_W-1:0]    cfg_wr_data,    // neighbor_count
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,        // time_value, zero pad
	input  logic [CMD_W-1:0]       s_tuser,        // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// entry_index, entry_time, distance, rank, error_seen, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast         // last_result
);

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KW    = $clog2(MAX_NEIGHBORS + 1);
	localparam int MW0   = (CNT_W > KW) ? CNT_W : KW;
	localparam int MW    = (MW0 > NCOUNT_W) ? MW0 : NCOUNT_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q;
	logic                err_q;
	logic [NCOUNT_W-1:0] ncfg_q;

	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] target_q;
	logic [CNT_W-1:0]  lo_q, hi_q, left_q, right_q;
	logic [IDX_W-1:0]  mid_q;
	logic [TIME_W-1:0] tl_q, dl_q, tr_q, dr_q;
	logic [KW-1:0]     k_q, n_q;
	logic              init_q, side_right_q;

	logic [ENTRY_INDEX_W-1:0] out_idx_q;
	logic [TIME_W-1:0]        out_time_q, out_dist_q;
	logic [RANK_W-1:0]        out_rank_q;
	logic                     out_last_q, out_err_q;

	logic [TIME_W-1:0] in_time;
	cmd_t              cmd;
	logic [TIME_W-1:0] rd_data, op_a, op_b;
	logic [IDX_W-1:0]  rd_addr;
	diff_t             diff_res;
	logic              full, order_bad, wr_en, accept;
	logic [MW-1:0]     k_min0, k_min;
	logic [KW-1:0]     k_start;
	logic [CNT_W-1:0]  mid_full, left_m1;
	logic              have_l, have_r, take_right;
	logic [KW-1:0]     n_p1;

	assign in_time   = s_tdata[TIME_W-1:0];
	assign cmd       = cmd_t'(s_tuser);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign order_bad = (count_q != '0) && diff_res.lt;
	assign wr_en     = accept && (cmd == CMD_APPEND) && !full && !order_bad;

	assign k_min0  = (MW'(ncfg_q) < MW'(MAX_NEIGHBORS)) ? MW'(ncfg_q) : MW'(MAX_NEIGHBORS);
	assign k_min   = (k_min0 < MW'(count_q)) ? k_min0 : MW'(count_q);
	assign k_start = KW'(k_min);

	assign mid_full   = lo_q + ((hi_q - lo_q) >> 1);
	assign left_m1    = left_q - 1'b1;
	assign have_l     = (left_q != '0);
	assign have_r     = (right_q < count_q);
	assign take_right = (have_l && have_r) ? diff_res.lt : !have_l;
	assign n_p1       = n_q + 1'b1;

	knts_ram #(
		.DATA_W (TIME_W),
		.DEPTH  (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (in_time),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	knts_diff_unit u_diff (
		.op_a (op_a),
		.op_b (op_b),
		.res  (diff_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		op_a    = in_time;
		op_b    = last_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_QUERY) && (k_start != '0)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					rd_addr = mid_full[IDX_W-1:0];
					state_d = ST_SRCH_CMP;
				end else begin
					state_d = ST_LOAD_L;
				end
			end
			ST_SRCH_CMP: begin
				op_a    = rd_data;
				op_b    = target_q;
				state_d = ST_SEARCH;
			end
			ST_LOAD_L: begin
				if (have_l) begin
					rd_addr = left_m1[IDX_W-1:0];
					state_d = ST_CALC_L;
				end else begin
					state_d = init_q ? ST_LOAD_R : ST_PICK;
				end
			end
			ST_CALC_L: begin
				op_a    = rd_data;
				op_b    = target_q;
				state_d = init_q ? ST_LOAD_R : ST_PICK;
			end
			ST_LOAD_R: begin
				if (have_r) begin
					rd_addr = right_q[IDX_W-1:0];
					state_d = ST_CALC_R;
				end else begin
					state_d = ST_PICK;
				end
			end
			ST_CALC_R: begin
				op_a    = rd_data;
				op_b    = target_q;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				// right wins only on strictly smaller distance
				op_a    = dr_q;
				op_b    = dl_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_tready) begin
					if (out_last_q) begin
						state_d = ST_IDLE;
					end else begin
						state_d = side_right_q ? ST_LOAD_R : ST_LOAD_L;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= 1'b0;
			ncfg_q  <= NCOUNT_W'(NEIGHBOR_RESET);
		end else begin
			if (cfg_wr_en) begin
				ncfg_q <= cfg_wr_data;
			end
			if (accept) begin
				case (cmd)
					CMD_APPEND: begin
						if (full || order_bad) begin
							err_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
					CMD_CLEAR: begin
						count_q <= '0;
						err_q   <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (wr_en) begin
					last_q <= in_time;
				end
				target_q <= in_time;
				lo_q     <= '0;
				hi_q     <= count_q;
				k_q      <= k_start;
				n_q      <= '0;
				init_q   <= 1'b1;
			end
			ST_SEARCH: begin
				mid_q   <= mid_full[IDX_W-1:0];
				left_q  <= lo_q;
				right_q <= lo_q;
			end
			ST_SRCH_CMP: begin
				if (diff_res.lt) begin
					lo_q <= CNT_W'(mid_q) + 1'b1;
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
			end
			ST_CALC_L: begin
				tl_q <= rd_data;
				dl_q <= diff_res.mag;
			end
			ST_CALC_R: begin
				tr_q <= rd_data;
				dr_q <= diff_res.mag;
			end
			ST_PICK: begin
				init_q       <= 1'b0;
				side_right_q <= take_right;
				out_rank_q   <= RANK_W'(n_q);
				out_last_q   <= (n_p1 == k_q);
				out_err_q    <= err_q;
				if (take_right) begin
					out_idx_q  <= ENTRY_INDEX_W'(right_q);
					out_time_q <= tr_q;
					out_dist_q <= dr_q;
					right_q    <= right_q + 1'b1;
				end else begin
					out_idx_q  <= ENTRY_INDEX_W'(left_m1);
					out_time_q <= tl_q;
					out_dist_q <= dl_q;
					left_q     <= left_m1;
				end
			end
			ST_EMIT: begin
				if (m_tready) begin
					n_q <= n_p1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_err_q, out_rank_q,
		out_dist_q, out_time_q, out_idx_q};

	`KNTS_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(TABLE_DEPTH), "entry count overflow")
	`KNTS_ASSERT(a_last_idle, clk, arst_n, (m_tvalid && m_tready && m_tlast) |=> s_tready, "not idle after last result")
	`KNTS_ASSERT(a_rank_bound, clk, arst_n, m_tvalid |-> (n_q < k_q), "result beyond neighbor limit")
	`KNTS_NEVER(a_ptr_order, clk, arst_n, ((state_q == ST_PICK) || (state_q == ST_EMIT)) && ((left_q > right_q) || (right_q > count_q)), "merge pointers out of order")

endmodule
